// ===== sv/ple_pkg.sv =====
// ----------------------------------------------------------------------------
// ple_pkg
// Request/response beat types and codes shared by the positional list engine.
// ----------------------------------------------------------------------------
`default_nettype none

package ple_pkg;

   localparam logic [1:0] MODE_INSERT  = 2'd0;
   localparam logic [1:0] MODE_READ    = 2'd1;
   localparam logic [1:0] MODE_REMOVE  = 2'd2;
   localparam logic [1:0] MODE_REVERSE = 2'd3;

   localparam logic [1:0] STATUS_OK     = 2'd0;
   localparam logic [1:0] STATUS_BADPOS = 2'd1;
   localparam logic [1:0] STATUS_FULL   = 2'd2;

   typedef struct packed {
      logic [1:0]         mode;
      logic [8:0]         position;
      logic signed [31:0] item_value;
   } ple_req_type;

   typedef struct packed {
      logic signed [31:0] read_value;
      logic [1:0]         status;
      logic [8:0]         element_count;
      logic               is_empty;
   } ple_rsp_type;

endpackage

`default_nettype wire

// ===== sv/ple_store.sv =====
// ----------------------------------------------------------------------------
// ple_store
// Element memory: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module ple_store #(
   parameter int DEPTH = 256,
   parameter int AW    = 8
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [AW-1:0]     wr_addr,
   input  wire logic [31:0]       wr_data,
   input  wire logic [AW-1:0]     rd_addr,
   output logic      [31:0]       rd_data
);

   logic [31:0] store_ff [DEPTH];
   logic [31:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= store_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== sv/ple_ctrl.sv =====
// ----------------------------------------------------------------------------
// ple_ctrl
// Request sequencer: checks the position, then walks the memory one entry per
// cycle with an address pointer (plus a high pointer for reverse) to shift, read or reverse the list.
// ----------------------------------------------------------------------------
`default_nettype none

module ple_ctrl #(
   parameter int CAPACITY = 256,
   parameter int AW       = 8,
   parameter int CW       = 9
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   input  wire ple_pkg::ple_req_type req,
   output logic                      busy,
   output logic                      mem_we,
   output logic [AW-1:0]             mem_waddr,
   output logic [31:0]               mem_wdata,
   output logic [AW-1:0]             mem_raddr,
   input  wire logic [31:0]          mem_rdata,
   output logic                      fin_valid,
   output ple_pkg::ple_rsp_type      fin_rsp
);

   import ple_pkg::*;

   localparam int EW = ((CW > 9) ? CW : 9) + 1;

   localparam logic [2:0] S_IDLE      = 3'd0;
   localparam logic [2:0] S_INS_SHIFT = 3'd1;
   localparam logic [2:0] S_INS_PUT   = 3'd2;
   localparam logic [2:0] S_RD_WAIT   = 3'd3;
   localparam logic [2:0] S_REM_SHIFT = 3'd4;
   localparam logic [2:0] S_REV_HI    = 3'd5;
   localparam logic [2:0] S_REV_LO    = 3'd6;

   logic [2:0]     state_ff, state_in;
   logic [CW-1:0]  count_ff, count_in;
   logic [AW-1:0]  ptr_ff, ptr_in;
   logic [AW-1:0]  hi_ff, hi_in;
   logic [AW-1:0]  pos_ff, pos_in;
   logic [31:0]    val_ff, val_in;

   logic [EW-1:0]  pos_e;
   logic [EW-1:0]  cnt_e;
   logic [AW-1:0]  idx;
   logic           fin;
   logic [1:0]     fin_status;
   logic [31:0]    fin_value;

   assign pos_e = EW'(req.position);
   assign cnt_e = EW'(count_ff);
   assign idx   = AW'(pos_e - EW'(1));

   always_comb begin
      state_in   = state_ff;
      count_in   = count_ff;
      ptr_in     = ptr_ff;
      hi_in      = hi_ff;
      pos_in     = pos_ff;
      val_in     = val_ff;
      mem_we     = 1'b0;
      mem_waddr  = ptr_ff;
      mem_wdata  = mem_rdata;
      mem_raddr  = '0;
      fin        = 1'b0;
      fin_status = STATUS_OK;
      fin_value  = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               pos_in = idx;
               val_in = req.item_value;
               unique case (req.mode)
                  MODE_INSERT: begin
                     if (pos_e == '0 || pos_e > cnt_e + EW'(1)) begin
                        fin        = 1'b1;
                        fin_status = STATUS_BADPOS;
                     end else if (cnt_e == EW'(CAPACITY)) begin
                        fin        = 1'b1;
                        fin_status = STATUS_FULL;
                     end else if (pos_e - EW'(1) == cnt_e) begin
                        state_in = S_INS_PUT;
                     end else begin
                        mem_raddr = AW'(cnt_e - EW'(1));
                        ptr_in    = AW'(cnt_e);
                        state_in  = S_INS_SHIFT;
                     end
                  end
                  MODE_READ: begin
                     if (pos_e == '0 || pos_e > cnt_e) begin
                        fin        = 1'b1;
                        fin_status = STATUS_BADPOS;
                     end else begin
                        mem_raddr = idx;
                        state_in  = S_RD_WAIT;
                     end
                  end
                  MODE_REMOVE: begin
                     if (pos_e == '0 || pos_e > cnt_e) begin
                        fin        = 1'b1;
                        fin_status = STATUS_BADPOS;
                     end else if (pos_e == cnt_e) begin
                        count_in = count_ff - CW'(1);
                        fin      = 1'b1;
                     end else begin
                        mem_raddr = AW'(pos_e);
                        ptr_in    = idx;
                        state_in  = S_REM_SHIFT;
                     end
                  end
                  MODE_REVERSE: begin
                     if (cnt_e > EW'(1)) begin
                        mem_raddr = '0;
                        ptr_in    = '0;
                        hi_in     = AW'(cnt_e - EW'(1));
                        state_in  = S_REV_HI;
                     end else begin
                        fin = 1'b1;
                     end
                  end
                  default: begin
                     fin = 1'b1;
                  end
               endcase
            end
         end
         S_INS_SHIFT: begin
            mem_we    = 1'b1;
            mem_waddr = ptr_ff;
            if (ptr_ff == pos_ff + AW'(1)) begin
               state_in = S_INS_PUT;
            end else begin
               mem_raddr = AW'({1'b0, ptr_ff} - (AW+1)'(2));
               ptr_in    = ptr_ff - AW'(1);
            end
         end
         S_INS_PUT: begin
            mem_we    = 1'b1;
            mem_waddr = pos_ff;
            mem_wdata = val_ff;
            count_in  = count_ff + CW'(1);
            fin       = 1'b1;
            state_in  = S_IDLE;
         end
         S_RD_WAIT: begin
            fin       = 1'b1;
            fin_value = mem_rdata;
            state_in  = S_IDLE;
         end
         S_REM_SHIFT: begin
            mem_we    = 1'b1;
            mem_waddr = ptr_ff;
            if (CW'(ptr_ff) + CW'(2) == count_ff) begin
               count_in = count_ff - CW'(1);
               fin      = 1'b1;
               state_in = S_IDLE;
            end else begin
               mem_raddr = AW'({1'b0, ptr_ff} + (AW+1)'(2));
               ptr_in    = ptr_ff + AW'(1);
            end
         end
         S_REV_HI: begin
            mem_raddr = hi_ff;
            mem_we    = 1'b1;
            mem_waddr = hi_ff;
            state_in  = S_REV_LO;
         end
         S_REV_LO: begin
            mem_we    = 1'b1;
            mem_waddr = ptr_ff;
            if ({1'b0, ptr_ff} + (AW+1)'(2) < {1'b0, hi_ff}) begin
               mem_raddr = ptr_ff + AW'(1);
               ptr_in    = ptr_ff + AW'(1);
               hi_in     = hi_ff - AW'(1);
               state_in  = S_REV_HI;
            end else begin
               fin      = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      ptr_ff <= ptr_in;
      hi_ff  <= hi_in;
      pos_ff <= pos_in;
      val_ff <= val_in;
   end

   assign busy                  = (state_ff != S_IDLE);
   assign fin_valid             = fin;
   assign fin_rsp.read_value    = fin_value;
   assign fin_rsp.status        = fin_status;
   assign fin_rsp.element_count = 9'(count_in);
   assign fin_rsp.is_empty      = (count_in == '0);

endmodule

`default_nettype wire

// ===== sv/positional_list_engine.sv =====
// ----------------------------------------------------------------------------
// positional_list_engine
// Ordered list of signed 32-bit values addressed by one-based position.
// ----------------------------------------------------------------------------
// Usage:
//   A request beat (req_data: mode, position, item_value) is taken on a clock
//   edge with start high and busy low. busy stays high while a multi-state
//   request runs. Each request gives exactly one response beat on rsp_data,
//   marked by rsp_strobe for one cycle; the receiver cannot stall it.
// Request steps (n = stored count):
//   rejected request, remove of the last entry, short reverse: answered from idle
//   read: one registered memory read, then the response
//   insert at k: entries k..n moved up one entry per cycle, then value written
//   remove at position k: entries k+1..n moved down one place
//   reverse: each pair swapped via S_REV_HI then S_REV_LO (one read port)
// Reset (synchronous) empties the list; memory contents are not cleared.
// A new request may start in the same cycle as the previous response strobe.
// ----------------------------------------------------------------------------
`default_nettype none

module positional_list_engine #(
   parameter int CAPACITY = 256
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   output logic                      busy,
   input  wire ple_pkg::ple_req_type req_data,
   output logic                      rsp_strobe,
   output ple_pkg::ple_rsp_type      rsp_data
);

   import ple_pkg::*;

   localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CW = $clog2(CAPACITY + 1);

   logic              mem_we;
   logic [AW-1:0]     mem_waddr;
   logic [31:0]       mem_wdata;
   logic [AW-1:0]     mem_raddr;
   logic [31:0]       mem_rdata;
   logic              fin_valid;
   ple_rsp_type       fin_rsp;

   logic              strobe_ff;
   ple_rsp_type       rsp_ff;

   ple_ctrl #(
      .CAPACITY (CAPACITY),
      .AW       (AW),
      .CW       (CW)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .req       (req_data),
      .busy      (busy),
      .mem_we    (mem_we),
      .mem_waddr (mem_waddr),
      .mem_wdata (mem_wdata),
      .mem_raddr (mem_raddr),
      .mem_rdata (mem_rdata),
      .fin_valid (fin_valid),
      .fin_rsp   (fin_rsp)
   );

   ple_store #(
      .DEPTH (CAPACITY),
      .AW    (AW)
   ) u_store (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= fin_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (fin_valid) begin
         rsp_ff <= fin_rsp;
      end
   end

   assign rsp_strobe = strobe_ff;
   assign rsp_data   = rsp_ff;

endmodule

`default_nettype wire

// ===== bench/tb_positional_list_engine.sv =====
// ----------------------------------------------------------------------------
// tb_positional_list_engine
// Self-checking bench for the positional list engine. A directed burst covers
// empty and one-entry lists, bad positions and value extremes; random traffic
// then grows the list to full, drains it, and mixes all modes. Every accepted
// request beat is run through a shadow list and the response beat is checked
// field by field, in order.
// ----------------------------------------------------------------------------
module tb_positional_list_engine;
   timeunit 1ns;
   timeprecision 1ps;

   import ple_pkg::*;

   localparam int CAPACITY   = 256;
   localparam int CYCLE_CAP  = 2_000_000;
   localparam int RAND_ITEMS = 1200;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   ple_req_type req_data;
   logic        rsp_strobe;
   ple_rsp_type rsp_data;

   positional_list_engine #(.CAPACITY(CAPACITY)) u_top (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

   ple_req_type       req_backlog [$];
   ple_rsp_type       expected_rsp [$];
   logic signed [31:0] shadow_list [CAPACITY];
   int                shadow_len = 0;
   int                gen_count = 0;
   int                beats_taken = 0;
   int                mismatches = 0;
   int                cycles = 0;
   logic              hold_off;

   initial clock = 1'b0;
   always #2 clock = ~clock;

   // shadow list: applies one request, returns the response it should give
   function automatic ple_rsp_type predict_list_op(ple_req_type rq);
      ple_rsp_type        r;
      int                 p;
      int                 k;
      int                 lo;
      int                 hi;
      logic signed [31:0] t;
      r = '0;
      r.status = STATUS_OK;
      p = int'(rq.position);
      case (rq.mode)
         MODE_INSERT: begin
            if (p < 1 || p > shadow_len + 1) begin
               r.status = STATUS_BADPOS;
            end else if (shadow_len >= CAPACITY) begin
               r.status = STATUS_FULL;
            end else begin
               for (k = shadow_len; k > p - 1; k--) shadow_list[k] = shadow_list[k-1];
               shadow_list[p-1] = rq.item_value;
               shadow_len++;
            end
         end
         MODE_READ: begin
            if (p < 1 || p > shadow_len) begin
               r.status = STATUS_BADPOS;
            end else begin
               r.read_value = shadow_list[p-1];
            end
         end
         MODE_REMOVE: begin
            if (p < 1 || p > shadow_len) begin
               r.status = STATUS_BADPOS;
            end else begin
               for (k = p - 1; k + 1 < shadow_len; k++) shadow_list[k] = shadow_list[k+1];
               shadow_len--;
            end
         end
         default: begin
            lo = 0;
            hi = shadow_len - 1;
            while (lo < hi) begin
               t = shadow_list[lo];
               shadow_list[lo] = shadow_list[hi];
               shadow_list[hi] = t;
               lo++;
               hi--;
            end
         end
      endcase
      r.element_count = shadow_len[8:0];
      r.is_empty = (shadow_len == 0);
      return r;
   endfunction

   // queue a request and track the list length it leaves behind
   task automatic push_item(logic [1:0] mode, int pos, logic [31:0] val);
      ple_req_type it;
      it.mode = mode;
      it.position = pos[8:0];
      it.item_value = val;
      pos = int'(it.position);
      if (mode == MODE_INSERT && pos >= 1 && pos <= gen_count + 1 && gen_count < CAPACITY)
         gen_count++;
      else if (mode == MODE_REMOVE && pos >= 1 && pos <= gen_count)
         gen_count--;
      req_backlog.push_back(it);
   endtask

   function automatic logic [31:0] pick_value();
      case ($urandom_range(15))
         0: return 32'h8000_0000;
         1: return 32'h7fff_ffff;
         2: return 32'hffff_ffff;
         3: return 32'h0;
         default: return $urandom;
      endcase
   endfunction

   // random request, mostly well formed, weighted toward insert or remove
   task automatic push_random(int ins_pct, int rem_pct);
      int roll;
      roll = $urandom_range(99);
      if (roll < 6)
         push_item(2'($urandom_range(3)), $urandom_range(511), pick_value());
      else if (roll < 9)
         push_item(MODE_REVERSE, $urandom_range(511), pick_value());
      else if (roll < 9 + ins_pct)
         push_item(MODE_INSERT, $urandom_range(gen_count + 1, 1), pick_value());
      else if (roll < 9 + ins_pct + rem_pct)
         push_item(MODE_REMOVE, gen_count == 0 ? 1 : $urandom_range(gen_count, 1),
                   pick_value());
      else
         push_item(MODE_READ, gen_count == 0 ? 1 : $urandom_range(gen_count, 1),
                   pick_value());
   endtask

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) begin
            expected_rsp.push_back(predict_list_op(req_data));
            beats_taken++;
         end
         if (!start || !busy) begin
            hold_off = (beats_taken < 500 || beats_taken >= 700) && ($urandom_range(99) < 18);
            if (req_backlog.size() > 0 && !hold_off) begin
               req_data <= req_backlog.pop_front();
               start <= 1'b1;
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   // response monitor
   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         if (expected_rsp.size() == 0) begin
            if (mismatches < 10)
               $display("unexpected rsp beat: value=%0d status=%0d count=%0d empty=%0b",
                        rsp_data.read_value, rsp_data.status, rsp_data.element_count,
                        rsp_data.is_empty);
            mismatches++;
         end else begin
            ple_rsp_type want;
            want = expected_rsp.pop_front();
            if (rsp_data.read_value !== want.read_value || rsp_data.status !== want.status ||
                rsp_data.element_count !== want.element_count ||
                rsp_data.is_empty !== want.is_empty) begin
               if (mismatches < 10)
                  $display("rsp mismatch: exp %0d/%0d/%0d/%0b got %0d/%0d/%0d/%0b",
                           want.read_value, want.status, want.element_count, want.is_empty,
                           rsp_data.read_value, rsp_data.status, rsp_data.element_count,
                           rsp_data.is_empty);
               mismatches++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles >= CYCLE_CAP) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   initial begin
      int n;
      reset = 1'b1;
      start = 1'b0;
      req_data = '0;

      // empty and one-entry lists, bad positions, value extremes
      push_item(MODE_READ,    1,   32'h0);
      push_item(MODE_REMOVE,  1,   32'h0);
      push_item(MODE_REVERSE, 0,   32'h0);
      push_item(MODE_INSERT,  0,   32'h1234_5678);
      push_item(MODE_INSERT,  2,   32'h1234_5678);
      push_item(MODE_INSERT,  1,   32'h8000_0000);
      push_item(MODE_REVERSE, 511, 32'hffff_ffff);
      push_item(MODE_INSERT,  2,   32'h7fff_ffff);
      push_item(MODE_INSERT,  1,   32'hffff_ffff);
      push_item(MODE_INSERT,  2,   32'h0);
      for (n = 1; n <= 4; n++) push_item(MODE_READ, n, 32'h0);
      push_item(MODE_READ,    5,   32'h0);
      push_item(MODE_READ,    511, 32'h0);
      push_item(MODE_REVERSE, 3,   32'h0);
      push_item(MODE_READ,    1,   32'h0);
      push_item(MODE_READ,    4,   32'h0);
      push_item(MODE_REMOVE,  4,   32'h0);
      push_item(MODE_REMOVE,  1,   32'h0);
      push_item(MODE_REMOVE,  0,   32'h0);
      push_item(MODE_INSERT,  511, 32'h5a5a_a5a5);
      push_item(MODE_INSERT,  256, 32'ha5a5_5a5a);

      // mixed traffic, then fill, full-list cases, drain, mixed again
      for (n = 0; n < 300; n++) push_random(35, 30);
      while (gen_count < CAPACITY) push_random(75, 5);
      push_item(MODE_INSERT,  1,            pick_value());
      push_item(MODE_INSERT,  CAPACITY + 1, pick_value());
      push_item(MODE_INSERT,  CAPACITY + 2, pick_value());
      push_item(MODE_INSERT,  511,          pick_value());
      push_item(MODE_READ,    CAPACITY,     32'h0);
      push_item(MODE_READ,    CAPACITY + 1, 32'h0);
      push_item(MODE_REVERSE, 0,            32'h0);
      push_item(MODE_READ,    1,            32'h0);
      push_item(MODE_REMOVE,  CAPACITY,     32'h0);
      push_item(MODE_INSERT,  128,          pick_value());
      push_item(MODE_INSERT,  100,          pick_value());
      while (gen_count > 0) push_random(5, 75);
      while (req_backlog.size() < RAND_ITEMS + 24) push_random(35, 30);

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      while (req_backlog.size() > 0 || start) @(posedge clock);
      while (expected_rsp.size() > 0) @(posedge clock);
      repeat (CAPACITY + 40) @(posedge clock);

      mismatches += expected_rsp.size();
      if (mismatches == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
